FILE: sv/bcps_pkg.sv
// Shared types and constants of the best-candidate point sampler.
package bcps_pkg;

  // Fixed field widths.
  localparam int COORD_BITS    = 16;
  localparam int FRAC_BITS     = 16;
  localparam int DIST_BITS     = 2 * COORD_BITS + 2;
  localparam int NUM_AXES      = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int GROUP_BITS    = 7;
  localparam int TARGET_BITS   = 9;
  localparam int INDEX_BITS    = 8;

  // Cycles from a sample entering the distance unit to its effect on the minimum.
  localparam int DIST_LAT = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [DIST_BITS-1:0]         dist_t;

  // Distance reported for an empty store: above any real distance.
  localparam dist_t DIST_EMPTY = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_X_BOUND_A  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_X_BOUND_B  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_BOUND_A  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_BOUND_B  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_Z_BOUND_A  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_Z_BOUND_B  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_GROUP_SIZE = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_CNT = 3'd7;

  // Configuration reset values.
  localparam coord_t                 BOUND_A_RST = 16'hFF00;
  localparam coord_t                 BOUND_B_RST = 16'h0100;
  localparam logic [GROUP_BITS-1:0]  GROUP_RST   = 7'd8;
  localparam logic [TARGET_BITS-1:0] TARGET_RST  = 9'd256;

  typedef struct packed {
    logic [FRAC_BITS-1:0] frac_x;
    logic [FRAC_BITS-1:0] frac_y;
    logic [FRAC_BITS-1:0] frac_z;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] point_index;
    coord_t                point_x;
    coord_t                point_y;
    coord_t                point_z;
    logic                  set_done;
  } out_item_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // What each cell of the point chain does in a cycle.
  typedef enum logic [1:0] {
    CHAIN_HOLD,
    CHAIN_ROTATE,
    CHAIN_PUSH
  } chain_mode_t;

  // Control from the sequencer to the distance unit.
  typedef struct packed {
    logic clear;
    logic sample;
  } dist_ctl_t;

endpackage

FILE: sv/bcps_cell.sv
// One cell of the point chain: holds one stored point.
module bcps_cell import bcps_pkg::*; (
  input  logic        clk,
  input  chain_mode_t mode,
  input  point_t      from_prev,
  input  point_t      from_next,
  output point_t      q
);

  point_t pt_r;

  // Rotate toward the head during a scan, shift away from it on insert.
  always_ff @(posedge clk) begin
    unique case (mode)
      CHAIN_HOLD:   pt_r <= pt_r;
      CHAIN_ROTATE: pt_r <= from_next;
      CHAIN_PUSH:   pt_r <= from_prev;
      default:      pt_r <= pt_r;
    endcase
  end

  assign q = pt_r;

endmodule

FILE: sv/bcps_dist.sv
// Pipelined squared distance and running minimum over the scanned points.
module bcps_dist import bcps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  dist_ctl_t ctl,
  input  point_t    pnt,
  input  point_t    cand,
  output dist_t     min_dist
);

  coord_t                    pa [NUM_AXES];
  coord_t                    ca [NUM_AXES];
  logic [COORD_BITS:0]       diff [NUM_AXES];
  logic [COORD_BITS-1:0]     absd_nxt [NUM_AXES];
  logic [COORD_BITS-1:0]     absd_r [NUM_AXES];
  logic [2*COORD_BITS-1:0]   sq_nxt [NUM_AXES];
  logic [2*COORD_BITS-1:0]   sq_r [NUM_AXES];
  dist_t                     sum_nxt;
  dist_t                     sum_r;
  dist_t                     min_nxt;
  dist_t                     min_r;
  logic                      v1_r;
  logic                      v2_r;
  logic                      v3_r;

  assign pa[0] = pnt.x;
  assign pa[1] = pnt.y;
  assign pa[2] = pnt.z;
  assign ca[0] = cand.x;
  assign ca[1] = cand.y;
  assign ca[2] = cand.z;

  // Stage 1: absolute difference per axis.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      diff[a] = {pa[a][COORD_BITS-1], pa[a]} - {ca[a][COORD_BITS-1], ca[a]};
      absd_nxt[a] = diff[a][COORD_BITS] ? COORD_BITS'(~diff[a] + 1'b1)
                                        : COORD_BITS'(diff[a]);
    end
  end

  // Stage 2: squares.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      sq_nxt[a] = (2*COORD_BITS)'(absd_r[a]) * (2*COORD_BITS)'(absd_r[a]);
    end
  end

  // Stage 3: sum of the three squares.
  assign sum_nxt = DIST_BITS'(sq_r[0]) + DIST_BITS'(sq_r[1]) + DIST_BITS'(sq_r[2]);

  // Running minimum, restarted for each candidate.
  always_comb begin
    min_nxt = min_r;
    if (ctl.clear) begin
      min_nxt = DIST_EMPTY;
    end else if (v3_r && (sum_r < min_r)) begin
      min_nxt = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    absd_r <= absd_nxt;
    sq_r   <= sq_nxt;
    sum_r  <= sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      min_r <= DIST_EMPTY;
    end else begin
      v1_r  <= ctl.sample;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      min_r <= min_nxt;
    end
  end

  assign min_dist = min_r;

endmodule

FILE: sv/best_candidate_point_sampler.sv
// Top level: scaling, point chain, distance unit and group sequencing.
// After the accepting edge the sequencer steps through order, multiply, add, scan, drain
// and decide; a result strobe follows decide when a group ends. A new item is taken only
// when idle, the pace set by the chain of stored points rotating past the single distance unit one point per cycle.
// Reset: control and configuration registers take their defaults, the store counts as empty; no clearing pass.
// Results are strobed for one cycle; the receiver cannot stall them.
module best_candidate_point_sampler import bcps_pkg::*; #(
  parameter int STORE_DEPTH = 256,
  parameter int MAX_GROUP   = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  output out_item_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int IDX_W     = (STORE_DEPTH > 2) ? $clog2(STORE_DEPTH) : 1;
  localparam int SC_W      = $clog2(STORE_DEPTH + 1);
  localparam int CNT_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP + 1) : 1;
  localparam int GCMP_W    = (CNT_W > GROUP_BITS) ? CNT_W : GROUP_BITS;
  localparam int TCMP_W    = (SC_W > TARGET_BITS) ? SC_W : TARGET_BITS;
  localparam int DRAIN_CYC = DIST_LAT - 1;
  localparam int DRAIN_W   = (DRAIN_CYC > 2) ? $clog2(DRAIN_CYC) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ORDER,
    ST_MULT,
    ST_ADD,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_t;

  // Control state.
  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       scan_r, scan_nxt;
  logic [DRAIN_W-1:0]     drain_r, drain_nxt;
  logic [SC_W-1:0]        stored_r, stored_nxt;
  logic [CNT_W-1:0]       cand_cnt_r, cand_cnt_nxt;
  dist_t                  best_dist_r, best_dist_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  // Configuration registers.
  coord_t                 bound_a_r [NUM_AXES];
  coord_t                 bound_b_r [NUM_AXES];
  coord_t                 bound_a_nxt [NUM_AXES];
  coord_t                 bound_b_nxt [NUM_AXES];
  logic [GROUP_BITS-1:0]  group_size_r, group_size_nxt;
  logic [TARGET_BITS-1:0] target_cnt_r, target_cnt_nxt;

  // Datapath registers.
  logic [FRAC_BITS-1:0]   frac_r [NUM_AXES];
  coord_t                 lo_r [NUM_AXES];
  logic [COORD_BITS-1:0]  span_r [NUM_AXES];
  logic [COORD_BITS-1:0]  off_r [NUM_AXES];
  coord_t                 cand_r [NUM_AXES];
  point_t                 best_pt_r;

  // Combinational datapath.
  coord_t                 lo_nxt [NUM_AXES];
  logic [COORD_BITS-1:0]  span_nxt [NUM_AXES];
  logic [COORD_BITS-1:0]  off_nxt [NUM_AXES];
  coord_t                 cand_nxt [NUM_AXES];
  logic [FRAC_BITS+COORD_BITS-1:0] prod [NUM_AXES];
  point_t                 cand_pt;
  point_t                 best_pt_nxt;
  logic                   take;
  logic                   group_end;
  logic                   set_end;
  logic [CNT_W-1:0]       cnt_inc;
  logic [CNT_W-1:0]       group_eff;
  logic [GCMP_W-1:0]      group_ext;
  logic [SC_W-1:0]        stored_inc;
  logic [SC_W-1:0]        target_eff;
  logic [TCMP_W-1:0]      target_ext;
  dist_t                  min_dist;
  dist_ctl_t              dist_ctl;
  chain_mode_t            chain_mode;
  point_t                 cell_q [STORE_DEPTH];

  // Configuration writes.
  always_comb begin
    bound_a_nxt    = bound_a_r;
    bound_b_nxt    = bound_b_r;
    group_size_nxt = group_size_r;
    target_cnt_nxt = target_cnt_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_X_BOUND_A:  bound_a_nxt[0] = cfg_data[COORD_BITS-1:0];
        REG_X_BOUND_B:  bound_b_nxt[0] = cfg_data[COORD_BITS-1:0];
        REG_Y_BOUND_A:  bound_a_nxt[1] = cfg_data[COORD_BITS-1:0];
        REG_Y_BOUND_B:  bound_b_nxt[1] = cfg_data[COORD_BITS-1:0];
        REG_Z_BOUND_A:  bound_a_nxt[2] = cfg_data[COORD_BITS-1:0];
        REG_Z_BOUND_B:  bound_b_nxt[2] = cfg_data[COORD_BITS-1:0];
        REG_GROUP_SIZE: group_size_nxt = cfg_data[GROUP_BITS-1:0];
        REG_TARGET_CNT: target_cnt_nxt = cfg_data[TARGET_BITS-1:0];
      endcase
    end
  end

  // Scaling: order the bounds, multiply the fraction by the span, add the low bound.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (bound_a_r[a] < bound_b_r[a]) begin
        lo_nxt[a]   = bound_a_r[a];
        span_nxt[a] = COORD_BITS'({bound_b_r[a][COORD_BITS-1], bound_b_r[a]}
                                  - {bound_a_r[a][COORD_BITS-1], bound_a_r[a]});
      end else begin
        lo_nxt[a]   = bound_b_r[a];
        span_nxt[a] = COORD_BITS'({bound_a_r[a][COORD_BITS-1], bound_a_r[a]}
                                  - {bound_b_r[a][COORD_BITS-1], bound_b_r[a]});
      end
      prod[a] = (FRAC_BITS+COORD_BITS)'(frac_r[a])
              * (FRAC_BITS+COORD_BITS)'(span_r[a]);
      off_nxt[a]  = prod[a][FRAC_BITS +: COORD_BITS];
      cand_nxt[a] = COORD_BITS'({lo_r[a][COORD_BITS-1], lo_r[a]} + {1'b0, off_r[a]});
    end
  end

  assign cand_pt = '{x: cand_r[0], y: cand_r[1], z: cand_r[2]};

  // Effective group size and target count, clamped to their legal ranges.
  assign group_ext  = GCMP_W'(group_size_r);
  assign target_ext = TCMP_W'(target_cnt_r);

  always_comb begin
    if (group_size_r == '0) begin
      group_eff = CNT_W'(1);
    end else if (group_ext > GCMP_W'(MAX_GROUP)) begin
      group_eff = CNT_W'(MAX_GROUP);
    end else begin
      group_eff = CNT_W'(group_ext);
    end
  end

  always_comb begin
    if (target_cnt_r == '0) begin
      target_eff = SC_W'(1);
    end else if (target_ext > TCMP_W'(STORE_DEPTH)) begin
      target_eff = SC_W'(STORE_DEPTH);
    end else begin
      target_eff = SC_W'(target_ext);
    end
  end

  // Group decision: the first candidate of a group always wins, later ones only if farther.
  assign take        = (cand_cnt_r == '0) || (min_dist > best_dist_r);
  assign best_pt_nxt = take ? cand_pt : best_pt_r;
  assign cnt_inc     = cand_cnt_r + CNT_W'(1);
  assign group_end   = (cnt_inc >= group_eff);
  assign stored_inc  = stored_r + SC_W'(1);
  assign set_end     = (stored_inc >= target_eff);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    drain_nxt     = drain_r;
    stored_nxt    = stored_r;
    cand_cnt_nxt  = cand_cnt_r;
    best_dist_nxt = best_dist_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_ORDER;
        end
      end
      ST_ORDER: state_nxt = ST_MULT;
      ST_MULT:  state_nxt = ST_ADD;
      ST_ADD: begin
        state_nxt = ST_SCAN;
        scan_nxt  = '0;
      end
      ST_SCAN: begin
        if (scan_r == IDX_W'(STORE_DEPTH - 1)) begin
          state_nxt = ST_DRAIN;
          drain_nxt = '0;
        end else begin
          scan_nxt = scan_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (drain_r == DRAIN_W'(DRAIN_CYC - 1)) begin
          state_nxt = ST_DECIDE;
        end else begin
          drain_nxt = drain_r + DRAIN_W'(1);
        end
      end
      ST_DECIDE: begin
        state_nxt = ST_IDLE;
        if (group_end) begin
          cand_cnt_nxt  = '0;
          best_dist_nxt = '0;
          stored_nxt    = set_end ? '0 : stored_inc;
          out_valid_nxt = 1'b1;
          out_data_nxt.point_index = INDEX_BITS'(stored_r);
          out_data_nxt.point_x     = best_pt_nxt.x;
          out_data_nxt.point_y     = best_pt_nxt.y;
          out_data_nxt.point_z     = best_pt_nxt.z;
          out_data_nxt.set_done    = set_end;
        end else begin
          cand_cnt_nxt  = cnt_inc;
          best_dist_nxt = take ? min_dist : best_dist_r;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scan_r       <= '0;
      drain_r      <= '0;
      stored_r     <= '0;
      cand_cnt_r   <= '0;
      best_dist_r  <= '0;
      out_valid_r  <= 1'b0;
      out_data_r   <= '0;
      bound_a_r    <= '{default: BOUND_A_RST};
      bound_b_r    <= '{default: BOUND_B_RST};
      group_size_r <= GROUP_RST;
      target_cnt_r <= TARGET_RST;
    end else begin
      state_r      <= state_nxt;
      scan_r       <= scan_nxt;
      drain_r      <= drain_nxt;
      stored_r     <= stored_nxt;
      cand_cnt_r   <= cand_cnt_nxt;
      best_dist_r  <= best_dist_nxt;
      out_valid_r  <= out_valid_nxt;
      out_data_r   <= out_data_nxt;
      bound_a_r    <= bound_a_nxt;
      bound_b_r    <= bound_b_nxt;
      group_size_r <= group_size_nxt;
      target_cnt_r <= target_cnt_nxt;
    end
  end

  // Datapath registers, loaded in their own state.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      frac_r[0] <= in_data.frac_x;
      frac_r[1] <= in_data.frac_y;
      frac_r[2] <= in_data.frac_z;
    end
    if (state_r == ST_ORDER) begin
      lo_r   <= lo_nxt;
      span_r <= span_nxt;
    end
    if (state_r == ST_MULT) begin
      off_r <= off_nxt;
    end
    if (state_r == ST_ADD) begin
      cand_r <= cand_nxt;
    end
    if (state_r == ST_DECIDE) begin
      best_pt_r <= best_pt_nxt;
    end
  end

  // Point chain: newest point at the head, rotated past the distance unit in a scan.
  always_comb begin
    if (state_r == ST_SCAN) begin
      chain_mode = CHAIN_ROTATE;
    end else if (state_r == ST_DECIDE && group_end) begin
      chain_mode = CHAIN_PUSH;
    end else begin
      chain_mode = CHAIN_HOLD;
    end
  end

  for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_chain
    point_t prev_pt;
    point_t next_pt;
    if (g == 0) begin : g_head
      assign prev_pt = best_pt_nxt;
    end else begin : g_body
      assign prev_pt = cell_q[g-1];
    end
    if (g == STORE_DEPTH - 1) begin : g_tail
      assign next_pt = cell_q[0];
    end else begin : g_inner
      assign next_pt = cell_q[g+1];
    end
    bcps_cell u_cell (
      .clk       (clk),
      .mode      (chain_mode),
      .from_prev (prev_pt),
      .from_next (next_pt),
      .q         (cell_q[g])
    );
  end

  // Only entries written in the current set take part in the minimum.
  assign dist_ctl.clear  = (state_r == ST_ADD);
  assign dist_ctl.sample = (state_r == ST_SCAN) && (SC_W'(scan_r) < stored_r);

  bcps_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (dist_ctl),
    .pnt      (cell_q[0]),
    .cand     (cand_pt),
    .min_dist (min_dist)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
